>>> design/double_ended_queue_defines.svh
// Assertion macros shared by the double-ended queue RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DDQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/ddq_pkg.sv
// Shared types, constants and pointer helpers for the double-ended queue.
// Depends on nothing; used by the top level.
`default_nettype none

package ddq_pkg;

	localparam int DEPTH     = 64;
	localparam int WORD_BITS = 32;
	localparam int IDX_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int KIND_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam int STAT_BITS = 2;
	localparam int OCC_BITS  = 7;

	localparam logic [KIND_BITS-1:0] K_PUSH_FRONT = 3'd0;
	localparam logic [KIND_BITS-1:0] K_PUSH_BACK  = 3'd1;
	localparam logic [KIND_BITS-1:0] K_POP_FRONT  = 3'd2;
	localparam logic [KIND_BITS-1:0] K_POP_BACK   = 3'd3;
	localparam logic [KIND_BITS-1:0] K_PEEK_FRONT = 3'd4;
	localparam logic [KIND_BITS-1:0] K_PEEK_BACK  = 3'd5;

	localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

	typedef logic [IDX_BITS-1:0] idx_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	// Information about one operation on its way from the RAM read to the output.
	typedef struct packed {
		logic                 is_read;
		logic [STAT_BITS-1:0] status;
		cnt_t                 occ;
	} ddq_res_t;

	function automatic idx_t step_up(input idx_t i);
		step_up = (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
	endfunction

	function automatic idx_t step_down(input idx_t i);
		step_down = (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
	endfunction

endpackage

`default_nettype wire

>>> design/ddq_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Generic; depends on nothing.
`default_nettype none

module ddq_ram #(
	parameter int DEPTH_P = 64,
	parameter int WIDTH_P = 32
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH_P)-1:0] waddr,
	input  wire logic [WIDTH_P-1:0]         wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH_P)-1:0] raddr,
	output logic      [WIDTH_P-1:0]         rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/double_ended_queue.sv
// Top level of the double-ended queue: pointer logic, RAM and output register.
// Depends on ddq_pkg, ddq_ram and double_ended_queue_defines.svh.
`default_nettype none
`include "double_ended_queue_defines.svh"

// The block is a double-ended queue of up to 64 signed 32-bit words held in a
// ring buffer in one synchronous RAM. Each input beat names one operation
// (push front or back, pop front or back, peek front or back) and yields
// exactly one output beat carrying the word read, a status and the number of
// words held afterwards. Pointers and the count are updated as the input beat
// is accepted, and the RAM is written or read in that same cycle; the read
// data is registered in the RAM and the result then passes from stage one
// into the output register. One beat is accepted every cycle while the
// output is not stalled, because the RAM read latency is covered by a
// one-deep stage and a separate output register. A push never collides
// with a later read of the same slot: the write lands before that read
// samples it. Popping or peeking an empty queue answers all ones with status
// empty; pushing onto a full queue drops the word with status full. Kinds
// six and seven do nothing and answer zero with status ok. The RAM needs no
// clearing after reset: only slots filled by a push are ever read.
module double_ended_queue (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [ddq_pkg::KIND_BITS-1:0]      kind,
	input  wire logic signed [ddq_pkg::DATA_BITS-1:0] push_word,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [ddq_pkg::DATA_BITS-1:0]    read_word,
	output logic      [ddq_pkg::STAT_BITS-1:0]      status,
	output logic      [ddq_pkg::OCC_BITS-1:0]       occupancy
);

	// Ring pointers and fill count.
	ddq_pkg::idx_t head_q;
	ddq_pkg::idx_t tail_q;
	ddq_pkg::cnt_t count_q;

	ddq_pkg::idx_t head_d;
	ddq_pkg::idx_t tail_d;
	ddq_pkg::cnt_t count_d;

	// Stage one: the operation whose RAM read is in flight.
	logic              valid_s1;
	ddq_pkg::ddq_res_t res_s1;
	ddq_pkg::ddq_res_t res_d;

	// Output register.
	logic                            out_valid_q;
	logic [ddq_pkg::DATA_BITS-1:0]   read_word_q;
	logic [ddq_pkg::STAT_BITS-1:0]   status_q;
	logic [ddq_pkg::OCC_BITS-1:0]    occupancy_q;

	logic                            in_acc;
	logic                            s1_adv;
	logic                            is_empty;
	logic                            is_full;
	logic                            mem_we;
	logic                            mem_re;
	ddq_pkg::idx_t                   waddr;
	ddq_pkg::idx_t                   raddr;
	logic [ddq_pkg::WORD_BITS-1:0]   rdata;

	// Stage one moves on when the output register is free or being emptied.
	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == ddq_pkg::cnt_t'(ddq_pkg::DEPTH));

	// Decode the operation: next pointers, RAM access and status.
	always_comb begin
		head_d       = head_q;
		tail_d       = tail_q;
		count_d      = count_q;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		waddr        = tail_q;
		raddr        = head_q;
		res_d.is_read = 1'b0;
		res_d.status  = ddq_pkg::ST_OK;
		unique case (kind) inside
			ddq_pkg::K_PUSH_FRONT, ddq_pkg::K_PUSH_BACK: begin
				if (is_full) begin
					res_d.status = ddq_pkg::ST_FULL;
				end else begin
					mem_we  = 1'b1;
					count_d = count_q + ddq_pkg::cnt_t'(1);
					if (kind == ddq_pkg::K_PUSH_FRONT) begin
						head_d = ddq_pkg::step_down(head_q);
						waddr  = ddq_pkg::step_down(head_q);
					end else begin
						tail_d = ddq_pkg::step_up(tail_q);
						waddr  = tail_q;
					end
				end
			end
			ddq_pkg::K_POP_FRONT, ddq_pkg::K_PEEK_FRONT: begin
				if (is_empty) begin
					res_d.status = ddq_pkg::ST_EMPTY;
				end else begin
					mem_re        = 1'b1;
					res_d.is_read = 1'b1;
					raddr         = head_q;
					if (kind == ddq_pkg::K_POP_FRONT) begin
						head_d  = ddq_pkg::step_up(head_q);
						count_d = count_q - ddq_pkg::cnt_t'(1);
					end
				end
			end
			ddq_pkg::K_POP_BACK, ddq_pkg::K_PEEK_BACK: begin
				if (is_empty) begin
					res_d.status = ddq_pkg::ST_EMPTY;
				end else begin
					mem_re        = 1'b1;
					res_d.is_read = 1'b1;
					raddr         = ddq_pkg::step_down(tail_q);
					if (kind == ddq_pkg::K_POP_BACK) begin
						tail_d  = ddq_pkg::step_down(tail_q);
						count_d = count_q - ddq_pkg::cnt_t'(1);
					end
				end
			end
			default: begin
				// Unused kinds leave everything as it is.
			end
		endcase
		res_d.occ = count_d;
	end

	ddq_ram #(
		.DEPTH_P (ddq_pkg::DEPTH),
		.WIDTH_P (ddq_pkg::WORD_BITS)
	) u_ram (
		.clk   (clk),
		.we    (in_acc && mem_we),
		.waddr (waddr),
		.wdata (ddq_pkg::WORD_BITS'(unsigned'(push_word))),
		.re    (in_acc && mem_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (in_acc) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// The RAM read data register holds while stage one waits, so only the
	// operation information needs to be kept here.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_s1 <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (res_s1.is_read) begin
				read_word_q <= ddq_pkg::DATA_BITS'(rdata);
			end else if (res_s1.status == ddq_pkg::ST_EMPTY) begin
				read_word_q <= '1;
			end else begin
				read_word_q <= '0;
			end
			status_q    <= res_s1.status;
			occupancy_q <= ddq_pkg::OCC_BITS'(res_s1.occ);
		end
	end

	assign out_valid = out_valid_q;
	assign read_word = signed'(read_word_q);
	assign status    = status_q;
	assign occupancy = occupancy_q;

	// The count never exceeds the ring size.
	`DDQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= ddq_pkg::cnt_t'(ddq_pkg::DEPTH))
	// An empty ring has its pointers together.
	`DDQ_ASSERT_SAME(a_empty_ptrs, is_empty, head_q == tail_q)
	// A push onto a full ring changes nothing.
	`DDQ_ASSERT_NEXT(a_full_push, in_acc && is_full && (kind == ddq_pkg::K_PUSH_FRONT || kind == ddq_pkg::K_PUSH_BACK), $stable(count_q) && $stable(head_q) && $stable(tail_q))
	// An empty answer always carries all ones.
	`DDQ_ASSERT_SAME(a_empty_word, out_valid_q && status_q == ddq_pkg::ST_EMPTY, read_word_q == '1)

endmodule

`default_nettype wire
